### rtl/aie_pkg.sv
// ----------------------------------------------------------------------------
// aie_pkg
// Shared types and constants of the accumulator instruction execute block.
// ----------------------------------------------------------------------------
package aie_pkg;

  localparam int unsigned MEM_WORDS_DEF  = 16;
  localparam logic [7:0]  START_PC_RESET = 8'd10;

  typedef enum logic [3:0] {
    OP_NONE  = 4'd0,
    OP_LOAD  = 4'd1,
    OP_ADD   = 4'd2,
    OP_STORE = 4'd3,
    OP_SUB   = 4'd4,
    OP_IN    = 4'd5,
    OP_OUT   = 4'd6,
    OP_HALT  = 4'd7,
    OP_JUMP  = 4'd8,
    OP_SKIPZ = 4'd9
  } opcode_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_HALT    = 2'd1,
    ST_BADOP   = 2'd2,
    ST_BADADDR = 2'd3
  } status_e;

  typedef struct packed {
    logic [3:0]         command;
    logic [7:0]         operand;
    logic signed [31:0] input_value;
  } req_t;

  typedef struct packed {
    logic [7:0]         pc;
    logic signed [31:0] acc_value;
    logic               output_strobe;
    logic [1:0]         status;
  } rsp_t;

endpackage

### rtl/aie_dmem.sv
// ----------------------------------------------------------------------------
// aie_dmem
// Data memory with one write and one registered read port. Per-entry valid
// bits cleared by reset make unwritten entries read as zero.
// ----------------------------------------------------------------------------
module aie_dmem
  import aie_pkg::*;
#(
  parameter int unsigned MemWords = MEM_WORDS_DEF,
  localparam int unsigned AddrW = $clog2(MemWords)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                rd_en_i,
  input  logic [AddrW-1:0]    rd_addr_i,
  output logic signed [31:0]  rd_data_o,
  input  logic                wr_en_i,
  input  logic [AddrW-1:0]    wr_addr_i,
  input  logic signed [31:0]  wr_data_i
);

  logic signed [31:0] mem [MemWords];
  logic [MemWords-1:0] vld_q;
  logic signed [31:0] rdata_q;
  logic               rvld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      rvld_q <= 1'b0;
    end else begin
      if (rd_en_i) begin
        rvld_q <= vld_q[rd_addr_i];
      end
      if (wr_en_i) begin
        vld_q[wr_addr_i] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rdata_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rvld_q ? rdata_q : '0;

endmodule

### rtl/accumulator_instruction_execute_top.sv
// ----------------------------------------------------------------------------
// accumulator_instruction_execute_top
// Execute unit of a simple accumulator machine, one instruction per request.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid_i/in_ready_o/in_req_i) carries one
//   instruction per request; the outside fetches it at the pc reported in
//   the previous result. The output channel (out_valid_o/out_ready_i/
//   out_rsp_o) returns pc, accumulator, output strobe and status for each
//   instruction, in order.
//   An accepted instruction is registered in the input register together
//   with the data memory read, then executed into the result register.
//   Throughput is one instruction per cycle while the receiver takes each
//   result; a store followed at once by a load of the same word is
//   forwarded, so it costs nothing extra.
//   A stalled receiver holds the result; one more instruction waits in the
//   input register, then in_ready_o drops until the result is taken.
//   Reset clears the accumulator, the status and all memory valid bits at
//   once and loads the pc with 10. cfg_we_i writes the start pc and loads
//   the pc with it; write it only while the block is idle.
//   After halt, a bad opcode or an out-of-range address the status sticks
//   and later instructions only report the held state.
// ----------------------------------------------------------------------------
module accumulator_instruction_execute_top
  import aie_pkg::*;
#(
  parameter int unsigned MEM_WORDS = MEM_WORDS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  req_t       in_req_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output rsp_t       out_rsp_o,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_wdata_i
);

  localparam int unsigned AddrW = $clog2(MEM_WORDS);

  logic               s1_valid_q;
  req_t               s1_req_q;
  logic               byp_hit_q;
  logic signed [31:0] byp_data_q;
  logic               out_valid_q;
  rsp_t               out_rsp_q;
  logic signed [31:0] acc_q, acc_d;
  logic [7:0]         pc_q, pc_d;
  status_e            stop_q, stop_d;

  logic               in_fire, ex_fire;
  logic               strobe;
  logic               wr_en;
  logic signed [31:0] rd_data;
  logic signed [31:0] mdata;
  logic               mem_op, in_range;

  assign ex_fire    = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || ex_fire;
  assign in_fire    = in_valid_i && in_ready_o;

  aie_dmem #(
    .MemWords (MEM_WORDS)
  ) u_dmem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (in_fire),
    .rd_addr_i (in_req_i.operand[AddrW-1:0]),
    .rd_data_o (rd_data),
    .wr_en_i   (wr_en),
    .wr_addr_i (s1_req_q.operand[AddrW-1:0]),
    .wr_data_i (acc_q)
  );

  assign mdata    = byp_hit_q ? byp_data_q : rd_data;
  assign in_range = {1'b0, s1_req_q.operand} < 9'(MEM_WORDS);
  assign mem_op   = (s1_req_q.command == OP_LOAD) || (s1_req_q.command == OP_ADD) ||
                    (s1_req_q.command == OP_STORE) || (s1_req_q.command == OP_SUB);

  always_comb begin
    acc_d  = acc_q;
    pc_d   = pc_q;
    stop_d = stop_q;
    strobe = 1'b0;
    wr_en  = 1'b0;
    if (stop_q != ST_OK) begin
      stop_d = stop_q;
    end else if (mem_op && !in_range) begin
      stop_d = ST_BADADDR;
    end else begin
      case (s1_req_q.command)
        OP_LOAD: begin
          acc_d = mdata;
          pc_d  = pc_q + 8'd1;
        end
        OP_ADD: begin
          acc_d = acc_q + mdata;
          pc_d  = pc_q + 8'd1;
        end
        OP_STORE: begin
          wr_en = ex_fire;
          pc_d  = pc_q + 8'd1;
        end
        OP_SUB: begin
          acc_d = acc_q - mdata;
          pc_d  = pc_q + 8'd1;
        end
        OP_IN: begin
          acc_d = s1_req_q.input_value;
          pc_d  = pc_q + 8'd1;
        end
        OP_OUT: begin
          strobe = 1'b1;
          pc_d   = pc_q + 8'd1;
        end
        OP_HALT: begin
          stop_d = ST_HALT;
        end
        OP_JUMP: begin
          pc_d = s1_req_q.operand;
        end
        OP_SKIPZ: begin
          pc_d = pc_q + ((acc_q == '0) ? 8'd2 : 8'd1);
        end
        default: begin
          stop_d = ST_BADOP;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      byp_hit_q   <= 1'b0;
      acc_q       <= '0;
      pc_q        <= START_PC_RESET;
      stop_q      <= ST_OK;
    end else begin
      if (in_fire) begin
        s1_valid_q <= 1'b1;
        byp_hit_q  <= wr_en && (s1_req_q.operand == in_req_i.operand);
      end else if (ex_fire) begin
        s1_valid_q <= 1'b0;
      end
      if (ex_fire) begin
        out_valid_q <= 1'b1;
        acc_q       <= acc_d;
        pc_q        <= pc_d;
        stop_q      <= stop_d;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        pc_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_req_q   <= in_req_i;
      byp_data_q <= acc_q;
    end
    if (ex_fire) begin
      out_rsp_q.pc            <= pc_d;
      out_rsp_q.acc_value     <= acc_d;
      out_rsp_q.output_strobe <= strobe;
      out_rsp_q.status        <= stop_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

endmodule

### rtl/aie_checker.sv
// ----------------------------------------------------------------------------
// aie_checker
// Port-level checks of the accumulator instruction execute block.
// ----------------------------------------------------------------------------
module aie_checker
  import aie_pkg::*;
(
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input req_t       in_req_i,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input rsp_t       out_rsp_o
);

  logic       stuck_q;
  rsp_t       last_q;
  logic       out_fire;

  assign out_fire = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stuck_q <= 1'b0;
      last_q  <= '0;
    end else if (out_fire) begin
      last_q <= out_rsp_o;
      if (out_rsp_o.status != ST_OK) begin
        stuck_q <= 1'b1;
      end
    end
  end

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_rsp_o))
    else $error("result changed while stalled");

  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i && $stable(in_req_i))
    else $error("request dropped or changed while waiting");

  a_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled with no result pending");

  a_strobe_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_rsp_o.output_strobe |-> out_rsp_o.status == ST_OK)
    else $error("output strobe with stopped status");

  a_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_fire && stuck_q |-> out_rsp_o.status == last_q.status &&
      out_rsp_o.pc == last_q.pc && out_rsp_o.acc_value == last_q.acc_value &&
      !out_rsp_o.output_strobe)
    else $error("state changed after stop");

endmodule

bind accumulator_instruction_execute_top aie_checker u_aie_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_req_i    (in_req_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_rsp_o   (out_rsp_o)
);

### test/accumulator_instruction_execute_checker.sv
// ----------------------------------------------------------------------------
// accumulator_instruction_execute_checker
// Watches the request, result and start-pc ports of the execute unit. It
// keeps its own accumulator machine and predicts one result per request,
// then compares each returned result field by field, in order.
// ----------------------------------------------------------------------------
module accumulator_instruction_execute_checker
  import aie_pkg::*;
#(
  parameter int unsigned MEM_WORDS = MEM_WORDS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_ready_i,
  input  req_t       in_req_i,
  input  logic       out_valid_i,
  input  logic       out_ready_i,
  input  rsp_t       out_rsp_i,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_wdata_i,
  output int         pending_o,
  output int         fail_count_o,
  output int         compared_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_PRINTED = 40;

  logic [7:0]  pc_q;
  logic [31:0] accum;
  logic [31:0] words [MEM_WORDS];
  status_e     halt_code;
  rsp_t        results_due [$];
  int          mismatches = 0;
  int          results_compared = 0;

  assign fail_count_o = mismatches;
  assign compared_o   = results_compared;

  task automatic report_mismatch(input string what);
    if (mismatches < MAX_PRINTED) begin
      $display("%0t ns: result %0d: %s", $realtime, results_compared, what);
    end
    mismatches++;
  endtask

  function automatic rsp_t run_instruction(input req_t r);
    rsp_t res;
    logic strobe;
    logic is_mem;
    strobe = 1'b0;
    is_mem = r.command inside {OP_LOAD, OP_ADD, OP_STORE, OP_SUB};
    if (halt_code == ST_OK) begin
      if (is_mem && r.operand >= MEM_WORDS) begin
        halt_code = ST_BADADDR;
      end else begin
        case (r.command)
          OP_LOAD: begin
            accum = words[r.operand];
            pc_q  = pc_q + 8'd1;
          end
          OP_ADD: begin
            accum = accum + words[r.operand];
            pc_q  = pc_q + 8'd1;
          end
          OP_STORE: begin
            words[r.operand] = accum;
            pc_q = pc_q + 8'd1;
          end
          OP_SUB: begin
            accum = accum - words[r.operand];
            pc_q  = pc_q + 8'd1;
          end
          OP_IN: begin
            accum = r.input_value;
            pc_q  = pc_q + 8'd1;
          end
          OP_OUT: begin
            strobe = 1'b1;
            pc_q   = pc_q + 8'd1;
          end
          OP_HALT: begin
            halt_code = ST_HALT;
          end
          OP_JUMP: begin
            pc_q = r.operand;
          end
          OP_SKIPZ: begin
            pc_q = pc_q + ((accum == '0) ? 8'd2 : 8'd1);
          end
          default: begin
            halt_code = ST_BADOP;
          end
        endcase
      end
    end
    res.pc            = pc_q;
    res.acc_value     = accum;
    res.output_strobe = strobe;
    res.status        = halt_code;
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    rsp_t want;
    if (!rst_ni) begin
      pc_q       = START_PC_RESET;
      accum      = '0;
      halt_code  = ST_OK;
      for (int w = 0; w < MEM_WORDS; w++) begin
        words[w] = '0;
      end
      results_due.delete();
      pending_o <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (results_due.size() == 0) begin
          report_mismatch($sformatf("result with nothing expected (pc %0d, status %0d)",
                                    out_rsp_i.pc, out_rsp_i.status));
        end else begin
          want = results_due.pop_front();
          if (out_rsp_i.pc !== want.pc) begin
            report_mismatch($sformatf("pc %0d, expected %0d", out_rsp_i.pc, want.pc));
          end
          if (out_rsp_i.acc_value !== want.acc_value) begin
            report_mismatch($sformatf("acc_value %0d, expected %0d",
                                      out_rsp_i.acc_value, want.acc_value));
          end
          if (out_rsp_i.output_strobe !== want.output_strobe) begin
            report_mismatch($sformatf("output_strobe %b, expected %b",
                                      out_rsp_i.output_strobe, want.output_strobe));
          end
          if (out_rsp_i.status !== want.status) begin
            report_mismatch($sformatf("status %0d, expected %0d",
                                      out_rsp_i.status, want.status));
          end
          results_compared++;
        end
      end
      if (cfg_we_i) begin
        pc_q = cfg_wdata_i;
      end
      if (in_valid_i && in_ready_i) begin
        results_due.push_back(run_instruction(in_req_i));
      end
      pending_o <= results_due.size();
    end
  end

endmodule

### test/accumulator_instruction_execute_top_test.sv
// ----------------------------------------------------------------------------
// accumulator_instruction_execute_top_test
// Drives instruction streams into the execute unit under several start-pc
// settings with random gaps and stalls, a long receiver hold-off and one
// sticky stop at the end; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module accumulator_instruction_execute_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import aie_pkg::*;

  localparam int CLK_PERIOD      = 20;
  localparam int RESET_CYCLES    = 10;
  localparam int DUT_LATENCY     = 2;
  localparam int PHASES          = 5;
  localparam int PHASE_ITEMS     = 250;
  localparam int TAIL_ITEMS      = 16;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int WATCHDOG_LIMIT  = 2000;

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_ready_o;
  req_t       in_req_i;
  logic       out_valid_o;
  logic       out_ready_i;
  rsp_t       out_rsp_o;
  logic       cfg_we_i;
  logic [7:0] cfg_wdata_i;

  int pending;
  int fail_count;
  int compared;

  bit calm = 1'b0;
  int hold_off_asked = 0;
  int hold_off_served = 0;
  int sent = 0;
  int settings = 1;

  accumulator_instruction_execute_top i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_rsp_o   (out_rsp_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  accumulator_instruction_execute_checker i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_i   (in_ready_o),
    .in_req_i     (in_req_i),
    .out_valid_i  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_rsp_i    (out_rsp_o),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .pending_o    (pending),
    .fail_count_o (fail_count),
    .compared_o   (compared)
  );

  initial begin
    clk_i = 1'b0;
    forever #(CLK_PERIOD / 2) clk_i = ~clk_i;
  end

  initial begin : receiver
    out_ready_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_off_asked != hold_off_served) begin
        out_ready_i <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk_i);
        hold_off_served++;
      end else if (calm || $urandom_range(99) >= 15) begin
        out_ready_i <= 1'b1;
      end else begin
        out_ready_i <= 1'b0;
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("timeout: no request or result moved for %0d cycles", WATCHDOG_LIMIT);
    $display("accumulator_instruction_execute_top_test failed");
    $finish;
  end

  function automatic req_t instr(input opcode_e op, input logic [7:0] opnd,
                                 input logic signed [31:0] val);
    req_t r;
    r.command     = op;
    r.operand     = opnd;
    r.input_value = val;
    return r;
  endfunction

  function automatic opcode_e pick_mem_op();
    opcode_e op;
    case ($urandom_range(3))
      0:       op = OP_LOAD;
      1:       op = OP_ADD;
      2:       op = OP_STORE;
      default: op = OP_SUB;
    endcase
    return op;
  endfunction

  function automatic req_t random_instr();
    req_t r;
    int   pick;
    int   vpick;
    pick          = $urandom_range(99);
    r.operand     = 8'($urandom);
    r.input_value = $urandom;
    if (pick < 60) begin
      r.command = pick_mem_op();
      r.operand = 8'($urandom_range(MEM_WORDS_DEF - 1));
    end else if (pick < 75) begin
      r.command = OP_IN;
      vpick = $urandom_range(99);
      if (vpick < 25) begin
        r.input_value = '0;
      end else if (vpick < 35) begin
        r.input_value = $urandom_range(1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
      end
    end else if (pick < 83) begin
      r.command = OP_OUT;
    end else if (pick < 90) begin
      r.command = OP_JUMP;
    end else begin
      r.command = OP_SKIPZ;
    end
    return r;
  endfunction

  task automatic send_instr(input req_t r);
    int gap;
    gap = 0;
    while (!calm && $urandom_range(99) < 15) gap++;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i   <= r;
    do @(posedge clk_i); while (!in_ready_o);
    sent++;
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  task automatic write_start_pc(input logic [7:0] value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    settings++;
  endtask

  task automatic run_directed();
    logic [7:0] top_word;
    top_word = 8'(MEM_WORDS_DEF - 1);
    send_instr(instr(OP_LOAD,  8'd5,     32'sd0));
    send_instr(instr(OP_SKIPZ, 8'hFF,    32'sh7FFF_FFFF));
    send_instr(instr(OP_IN,    8'd0,     32'sh7FFF_FFFF));
    send_instr(instr(OP_STORE, 8'd0,     32'sh8000_0000));
    send_instr(instr(OP_ADD,   8'd0,     32'sd0));
    send_instr(instr(OP_OUT,   8'hFF,    -32'sd1));
    send_instr(instr(OP_IN,    8'hFF,    32'sh8000_0000));
    send_instr(instr(OP_STORE, top_word, 32'sd0));
    send_instr(instr(OP_SUB,   8'd0,     32'sd0));
    send_instr(instr(OP_SKIPZ, 8'd0,     32'sd0));
    send_instr(instr(OP_SUB,   top_word, 32'sd0));
    send_instr(instr(OP_LOAD,  top_word, 32'sd0));
    send_instr(instr(OP_ADD,   top_word, 32'sd0));
    send_instr(instr(OP_SKIPZ, 8'd0,     32'sd0));
    send_instr(instr(OP_JUMP,  8'hFF,    32'sd0));
    send_instr(instr(OP_OUT,   8'd0,     32'sd0));
    send_instr(instr(OP_JUMP,  8'hFE,    32'sd0));
    send_instr(instr(OP_SKIPZ, 8'd0,     32'sd0));
    send_instr(instr(OP_IN,    8'd0,     -32'sd1));
    send_instr(instr(OP_OUT,   8'd0,     32'sd0));
    send_instr(instr(OP_JUMP,  8'd0,     32'sd0));
  endtask

  initial begin : stimulus
    req_t       r;
    int         stop_kind;
    int         code;
    string      stop_name;
    logic [7:0] phase_pc;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_req_i    = '0;
    cfg_we_i    = 1'b0;
    cfg_wdata_i = '0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    run_directed();

    for (int phase = 0; phase < PHASES; phase++) begin
      wait_drained();
      case (phase)
        0:       phase_pc = 8'd0;
        1:       phase_pc = 8'hFF;
        3:       phase_pc = 8'd128;
        default: phase_pc = 8'($urandom_range(255));
      endcase
      write_start_pc(phase_pc);
      calm = (phase == 1);
      if (phase == 2) begin
        hold_off_asked++;
      end
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        send_instr(random_instr());
        if (phase == 3 && i == PHASE_ITEMS / 2) begin
          wait_drained();
        end
      end
    end
    calm = 1'b0;

    // end the program with one sticky stop, then feed requests it must ignore
    r = random_instr();
    stop_kind = $urandom_range(2);
    case (stop_kind)
      0: begin
        r.command = OP_HALT;
        stop_name = "halt";
      end
      1: begin
        code = $urandom_range(10, 16);
        r.command = (code == 16) ? OP_NONE : 4'(code);
        stop_name = "bad opcode";
      end
      default: begin
        r.command = pick_mem_op();
        r.operand = 8'($urandom_range(MEM_WORDS_DEF, 255));
        stop_name = "bad address";
      end
    endcase
    send_instr(r);
    for (int i = 0; i < TAIL_ITEMS; i++) begin
      r.command     = 4'($urandom_range(15));
      r.operand     = 8'($urandom);
      r.input_value = $urandom;
      send_instr(r);
    end

    wait_drained();
    repeat (DUT_LATENCY + 2) @(posedge clk_i);

    $display("Sent %0d requests under %0d start-pc settings, ending on a %s stop;",
             sent, settings, stop_name);
    $display("compared %0d results, %0d field mismatches.", compared, fail_count);
    if (fail_count == 0 && pending == 0) begin
      $display("accumulator_instruction_execute_top_test passed");
    end else begin
      $display("accumulator_instruction_execute_top_test failed");
    end
    $finish;
  end

endmodule

### sim.f
rtl/aie_pkg.sv
rtl/aie_dmem.sv
rtl/accumulator_instruction_execute_top.sv
rtl/aie_checker.sv
test/accumulator_instruction_execute_checker.sv
test/accumulator_instruction_execute_top_test.sv
